// ===== design/i2c_bit_master_core_macros.svh =====
// Assertion macros for the i2c_bit_master_core checker.
// Depends on nothing; included by the checker file only.
`ifndef I2C_BIT_MASTER_CORE_MACROS_SVH
`define I2C_BIT_MASTER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define I2CBM_ASSERT_NOW(lbl, clk, rst_n, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (con)) \
    else $error("%m: check failed");

// Next-cycle implication, ignored while reset is asserted.
`define I2CBM_ASSERT_NXT(lbl, clk, rst_n, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (con)) \
    else $error("%m: check failed");

// Next-cycle implication that also covers the reset cycles.
`define I2CBM_ASSERT_NXT_ALWAYS(lbl, clk, ant, con) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) \
    else $error("%m: check failed");

`endif

// ===== design/i2cbm_pkg.sv =====
// Shared types, codes and helpers of the I2C bit master.
// No dependencies.
`default_nettype none

package i2cbm_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // One tick as the back end consumes it.
  typedef struct packed {
    logic       cmd_valid;
    op_t        op;
    logic [7:0] wbyte;
    logic       sda;
  } tick_t;

  typedef enum logic [11:0] {
    PH_IDLE    = 12'b0000_0000_0001,
    PH_START_A = 12'b0000_0000_0010,
    PH_START_B = 12'b0000_0000_0100,
    PH_STOP_A  = 12'b0000_0000_1000,
    PH_WR_HIGH = 12'b0000_0001_0000,
    PH_WR_LOW  = 12'b0000_0010_0000,
    PH_ACK_CLK = 12'b0000_0100_0000,
    PH_ACK_REL = 12'b0000_1000_0000,
    PH_ACK_LOW = 12'b0001_0000_0000,
    PH_ACK_END = 12'b0010_0000_0000,
    PH_RD_HIGH = 12'b0100_0000_0000,
    PH_RD_LOW  = 12'b1000_0000_0000
  } phase_t;

  localparam logic        REG_SHORT   = 1'b0;
  localparam logic        REG_LONG    = 1'b1;
  localparam logic [15:0] SHORT_RESET = 16'd50;
  localparam logic [15:0] LONG_RESET  = 16'd100;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

  // Count loaded for a hold of t ticks; zero counts as one tick.
  function automatic logic [15:0] hold_cnt(input logic [15:0] t);
    return (t == 16'd0) ? 16'd0 : t - 16'd1;
  endfunction

endpackage

`default_nettype wire

// ===== design/i2cbm_if.sv =====
// Valid/ready channel interfaces for ticks in and line states out.
// No dependencies.
`default_nettype none

interface i2cbm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] operation;
  logic [7:0] write_byte;
  logic       sda_in;

  modport source (output valid, cmd_valid, operation, write_byte, sda_in, input ready);
  modport sink   (input valid, cmd_valid, operation, write_byte, sda_in, output ready);
  modport mon    (input valid, ready, cmd_valid, operation, write_byte, sda_in);
endinterface

interface i2cbm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_pull_low;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic       acked;
  logic [7:0] read_byte;

  modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res, acked,
                  read_byte, input ready);
  modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, done_res, acked,
                  read_byte, output ready);
  modport mon    (input valid, ready, scl_pull_low, sda_pull_low, busy_res, done_res,
                  acked, read_byte);
endinterface

`default_nettype wire

// ===== design/i2c_bit_master_core.sv =====
// Top level of the I2C bit master: register port, front end, queue, back end.
// Depends on i2cbm_pkg, i2cbm_if, i2cbm_front, i2cbm_queue and i2cbm_back.
`default_nettype none

// Open-drain I2C master stepped by ticks. Each transfer on the input channel
// is one tick of the bit timer and yields exactly one transfer on the output
// channel, showing the SCL/SDA pull-low levels, busy, done, the last write's
// acknowledge (1 when the slave held SDA low) and the last byte read. A
// command (start, stop, write byte, read byte) offered with cmd_valid on an
// idle tick is taken; while busy, and on the tick a command completes, it is
// ignored. Ticks are taken one per clock cycle, sustained: the front end
// classifies a tick and pushes it into a QUEUE_DEPTH-entry queue, the back end
// pops one entry per cycle and carries out one step of its sequencer in that
// cycle, and an output register holds the result, so a stalled output lets
// the queue fill before the input channel stalls. A tick is held in the queue
// and its result in the output register. Register 0 (address 0) is the
// short hold in ticks (reset 50), register 1 (address 4) the long hold, one
// SCL half period of a data bit (reset 100); a value of zero acts as one.
// Write the registers only while no tick is in flight.
module i2c_bit_master_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  i2cbm_in_if.sink         in_if,
  i2cbm_out_if.source      out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import i2cbm_pkg::*;

  logic [15:0] short_r, short_nxt;
  logic [15:0] long_r, long_nxt;
  logic        wr_en;

  tick_t q_in, q_head;
  logic  q_push, q_pop, q_full, q_empty;

  // Register port: no wait states; paddr[2] picks the register.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    short_nxt = short_r;
    long_nxt  = long_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_SHORT: short_nxt = pwdata[15:0];
        REG_LONG:  long_nxt  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= SHORT_RESET;
      long_r  <= LONG_RESET;
    end else begin
      short_r <= short_nxt;
      long_r  <= long_nxt;
    end
  end

  // Read back the selected hold, zero-extended.
  assign prdata = {16'd0, (paddr[2] == REG_LONG) ? long_r : short_r};

  // Classify incoming ticks; stall input only when the queue is full.
  i2cbm_front u_front (
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // Decouple the input side from the sequencer and output stalls.
  i2cbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Advance the bus sequencer one tick per popped entry.
  i2cbm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .short_ticks (short_r),
    .long_ticks  (long_r),
    .out_if      (out_if)
  );
endmodule

`default_nettype wire

// ===== design/i2cbm_front.sv =====
// Front end: takes ticks from the input channel and classifies them.
// Depends on i2cbm_pkg and i2cbm_if.
`default_nettype none

module i2cbm_front (
  i2cbm_in_if.sink        in_if,
  input  wire logic       q_full,
  output logic            q_push,
  output i2cbm_pkg::tick_t q_data
);
  import i2cbm_pkg::*;

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  always_comb begin
    q_data.cmd_valid = in_if.cmd_valid;
    q_data.op        = op_t'(in_if.operation);
    // keep the byte only where a write will load it
    q_data.wbyte     = (in_if.cmd_valid && op_t'(in_if.operation) == OP_WRITE) ?
                       in_if.write_byte : 8'd0;
    q_data.sda       = in_if.sda_in;
  end
endmodule

`default_nettype wire

// ===== design/i2cbm_queue.sv =====
// Short tick queue between the front and back ends.
// Depends on i2cbm_pkg.
`default_nettype none

module i2cbm_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  i2cbm_pkg::tick_t      push_data,
  input  wire logic             pop,
  output i2cbm_pkg::tick_t      head,
  output logic                  full,
  output logic                  empty
);
  import i2cbm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tick_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

`default_nettype wire

// ===== design/i2cbm_back.sv =====
// Back end: steps the bus sequencer one tick per queue entry.
// Depends on i2cbm_pkg and i2cbm_if.
`default_nettype none

module i2cbm_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  i2cbm_pkg::tick_t head,
  input  wire logic        q_empty,
  output logic             q_pop,
  input  wire logic [15:0] short_ticks,
  input  wire logic [15:0] long_ticks,
  i2cbm_out_if.source      out_if
);
  import i2cbm_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic        ack_r, ack_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic [7:0]  last_rd_r, last_rd_nxt;
  logic        done;

  logic        out_valid_r;
  logic        o_scl_r, o_sda_r, o_busy_r, o_done_r, o_ack_r;
  logic [7:0]  o_rd_r;

  // advance one tick whenever the output slot is free or being drained
  assign q_pop = !q_empty && (!out_valid_r || out_if.ready);

  always_comb begin
    phase_nxt   = phase_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    delay_nxt   = delay_r;
    ack_nxt     = ack_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    last_rd_nxt = last_rd_r;
    done        = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (head.cmd_valid) begin
        bit_nxt = 4'd0;
        unique case (head.op)
          OP_START: begin
            phase_nxt = PH_START_A; scl_nxt = 1'b0; sda_nxt = 1'b1;
            delay_nxt = hold_cnt(short_ticks);
          end
          OP_STOP: begin
            phase_nxt = PH_STOP_A; scl_nxt = 1'b0; sda_nxt = 1'b1;
            delay_nxt = hold_cnt(short_ticks);
          end
          OP_WRITE: begin
            shift_nxt = head.wbyte;
            phase_nxt = PH_WR_HIGH; scl_nxt = 1'b0; sda_nxt = !head.wbyte[7];
            delay_nxt = hold_cnt(long_ticks);
          end
          OP_READ: begin
            shift_nxt = 8'd0;
            phase_nxt = PH_RD_HIGH; scl_nxt = 1'b0; sda_nxt = 1'b0;
            delay_nxt = hold_cnt(long_ticks);
          end
          default: ;
        endcase
      end
    end else if (delay_r != 16'd0) begin
      delay_nxt = delay_r - 16'd1;
    end else begin
      unique case (phase_r)
        PH_START_A: begin
          phase_nxt = PH_START_B; scl_nxt = 1'b1;
          delay_nxt = hold_cnt(short_ticks);
        end
        PH_START_B: begin
          phase_nxt = PH_IDLE; done = 1'b1;
        end
        PH_STOP_A: begin
          sda_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1;
        end
        PH_WR_HIGH: begin
          phase_nxt = PH_WR_LOW; scl_nxt = 1'b1;
          delay_nxt = hold_cnt(long_ticks);
        end
        PH_WR_LOW: begin
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_r + 4'd1;
          delay_nxt = hold_cnt(long_ticks);
          scl_nxt   = 1'b0;
          if (bit_nxt < BITS_PER_BYTE) begin
            phase_nxt = PH_WR_HIGH; sda_nxt = !shift_r[6];
          end else begin
            phase_nxt = PH_ACK_CLK;
          end
        end
        PH_ACK_CLK: begin
          phase_nxt = PH_ACK_REL; scl_nxt = 1'b0; sda_nxt = 1'b0;
          delay_nxt = hold_cnt(short_ticks);
        end
        PH_ACK_REL: begin
          ack_nxt   = !head.sda;
          phase_nxt = PH_ACK_LOW; scl_nxt = 1'b1; sda_nxt = 1'b0;
          delay_nxt = hold_cnt(long_ticks);
        end
        PH_ACK_LOW: begin
          phase_nxt = PH_ACK_END; scl_nxt = 1'b1; sda_nxt = 1'b1;
          delay_nxt = hold_cnt(short_ticks);
        end
        PH_ACK_END: begin
          phase_nxt = PH_IDLE; done = 1'b1;
        end
        PH_RD_HIGH: begin
          shift_nxt = {shift_r[6:0], head.sda};
          phase_nxt = PH_RD_LOW; scl_nxt = 1'b1; sda_nxt = 1'b0;
          delay_nxt = hold_cnt(long_ticks);
        end
        PH_RD_LOW: begin
          bit_nxt = bit_r + 4'd1;
          if (bit_nxt < BITS_PER_BYTE) begin
            phase_nxt = PH_RD_HIGH; scl_nxt = 1'b0; sda_nxt = 1'b0;
            delay_nxt = hold_cnt(long_ticks);
          end else begin
            last_rd_nxt = shift_r;
            phase_nxt   = PH_IDLE; done = 1'b1;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_r     <= 4'd0;
      shift_r   <= 8'd0;
      delay_r   <= 16'd0;
      ack_r     <= 1'b0;
      scl_r     <= 1'b0;
      sda_r     <= 1'b0;
      last_rd_r <= 8'd0;
    end else if (q_pop) begin
      phase_r   <= phase_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      delay_r   <= delay_nxt;
      ack_r     <= ack_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      last_rd_r <= last_rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      o_scl_r  <= scl_nxt;
      o_sda_r  <= sda_nxt;
      o_busy_r <= (phase_nxt != PH_IDLE);
      o_done_r <= done;
      o_ack_r  <= ack_nxt;
      o_rd_r   <= last_rd_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.scl_pull_low = o_scl_r;
  assign out_if.sda_pull_low = o_sda_r;
  assign out_if.busy_res     = o_busy_r;
  assign out_if.done_res     = o_done_r;
  assign out_if.acked        = o_ack_r;
  assign out_if.read_byte    = o_rd_r;
endmodule

`default_nettype wire

// ===== design/i2cbm_checker.sv =====
// Port-level checks of i2c_bit_master_core and the bind that attaches them.
// Depends on i2cbm_if and i2c_bit_master_core_macros.svh.
`default_nettype none
`include "i2c_bit_master_core_macros.svh"

module i2cbm_checker (
  input wire logic    clk,
  input wire logic    rst_n,
  i2cbm_out_if.source out_if
);

  logic        out_fire;
  logic        idle_fire;
  logic        done_seen;
  logic [12:0] out_word;

  assign out_fire  = out_if.valid && out_if.ready;
  assign idle_fire = out_fire && !out_if.busy_res;
  assign done_seen = out_if.valid && out_if.done_res;
  assign out_word  = {out_if.scl_pull_low, out_if.sda_pull_low, out_if.busy_res,
                      out_if.done_res, out_if.acked, out_if.read_byte};

  // Hold a stalled result transfer.
  `I2CBM_ASSERT_NXT(a_out_hold, clk, rst_n, out_if.valid && !out_if.ready, out_if.valid && $stable(out_word))

  // A finishing tick leaves the sequencer idle.
  `I2CBM_ASSERT_NOW(a_done_idle, clk, rst_n, done_seen, !out_if.busy_res)

  // Drop any pending result on reset.
  `I2CBM_ASSERT_NXT_ALWAYS(a_rst_clear, clk, !rst_n, !out_if.valid)

  // A command only finishes after a busy tick.
  `I2CBM_ASSERT_NXT(a_done_after_busy, clk, rst_n, idle_fire, !done_seen)

endmodule

bind i2c_bit_master_core i2cbm_checker u_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_if (out_if)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for i2c_bit_master_core: drives ticks and checks line states.
// Depends on i2cbm_pkg, i2cbm_if and the i2c_bit_master_core RTL.
`timescale 1ns / 100ps

module testbench;
  import i2cbm_pkg::*;

  // Line state after one tick, as the output channel carries it.
  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy;
    logic       done;
    logic       acked;
    logic [7:0] rbyte;
  } line_state_t;

  // Tracks the bit sequencer tick by tick and holds the line states still owed.
  class i2c_line_tracker;
    logic [15:0] short_ticks;
    logic [15:0] long_ticks;
    phase_t      phase;
    logic [3:0]  bit_cnt;
    logic [7:0]  shifter;
    logic [15:0] hold_left;
    logic        ack;
    logic        scl_low;
    logic        sda_low;
    logic [7:0]  last_byte;
    line_state_t expected_lines[$];
    int          ticks;
    int          results;
    int          errors;

    function new();
      short_ticks = SHORT_RESET;
      long_ticks  = LONG_RESET;
      phase       = PH_IDLE;
      bit_cnt     = '0;
      shifter     = '0;
      hold_left   = '0;
      ack         = 1'b0;
      scl_low     = 1'b0;
      sda_low     = 1'b0;
      last_byte   = '0;
      ticks       = 0;
      results     = 0;
      errors      = 0;
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    // Move to a phase, set both lines and load the hold; zero acts as one tick.
    function void set_lines(phase_t ph, logic scl, logic sda, logic [15:0] n);
      logic [15:0] d;
      d         = (n == 16'd0) ? 16'd1 : n;
      phase     = ph;
      scl_low   = scl;
      sda_low   = sda;
      hold_left = d - 16'd1;
    endfunction

    // SCL released, SDA low for a zero bit and released for a one.
    function void send_bit();
      set_lines(PH_WR_HIGH, 1'b0, ~shifter[7], long_ticks);
    endfunction

    function void advance_sequencer(tick_t t);
      line_state_t r;
      logic        fin;
      fin = 1'b0;
      if (phase == PH_IDLE) begin
        if (t.cmd_valid) begin
          bit_cnt = '0;
          case (t.op)
            OP_START: set_lines(PH_START_A, 1'b0, 1'b1, short_ticks);
            OP_STOP:  set_lines(PH_STOP_A, 1'b0, 1'b1, short_ticks);
            OP_WRITE: begin
              shifter = t.wbyte;
              send_bit();
            end
            default: begin
              shifter = '0;
              set_lines(PH_RD_HIGH, 1'b0, 1'b0, long_ticks);
            end
          endcase
        end
      end else if (hold_left != 16'd0) begin
        hold_left = hold_left - 16'd1;
      end else begin
        case (phase)
          PH_START_A: set_lines(PH_START_B, 1'b1, sda_low, short_ticks);
          PH_START_B: begin
            phase = PH_IDLE;
            fin   = 1'b1;
          end
          PH_STOP_A: begin
            sda_low = 1'b0;
            phase   = PH_IDLE;
            fin     = 1'b1;
          end
          PH_WR_HIGH: set_lines(PH_WR_LOW, 1'b1, sda_low, long_ticks);
          PH_WR_LOW: begin
            shifter = shifter << 1;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < BITS_PER_BYTE) begin
              send_bit();
            end else begin
              set_lines(PH_ACK_CLK, 1'b0, sda_low, long_ticks);
            end
          end
          PH_ACK_CLK: set_lines(PH_ACK_REL, 1'b0, 1'b0, short_ticks);
          PH_ACK_REL: begin
            ack = ~t.sda;
            set_lines(PH_ACK_LOW, 1'b1, 1'b0, long_ticks);
          end
          PH_ACK_LOW: set_lines(PH_ACK_END, 1'b1, 1'b1, short_ticks);
          PH_ACK_END: begin
            phase = PH_IDLE;
            fin   = 1'b1;
          end
          PH_RD_HIGH: begin
            shifter = {shifter[6:0], t.sda};
            set_lines(PH_RD_LOW, 1'b1, 1'b0, long_ticks);
          end
          PH_RD_LOW: begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < BITS_PER_BYTE) begin
              set_lines(PH_RD_HIGH, 1'b0, 1'b0, long_ticks);
            end else begin
              last_byte = shifter;
              phase     = PH_IDLE;
              fin       = 1'b1;
            end
          end
          default: phase = PH_IDLE;
        endcase
      end
      r.scl_low = scl_low;
      r.sda_low = sda_low;
      r.busy    = (phase != PH_IDLE);
      r.done    = fin;
      r.acked   = ack;
      r.rbyte   = last_byte;
      expected_lines.push_back(r);
    endfunction

    function void note_tick(tick_t t);
      ticks++;
      advance_sequencer(t);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task cmp(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s got %0h expected %0h", results, name, got, want));
      end
    endtask

    task check_lines(line_state_t got);
      line_state_t want;
      if (expected_lines.size() == 0) begin
        report($sformatf("result %0d arrived with no tick outstanding", results));
      end else begin
        want = expected_lines.pop_front();
        cmp("scl_pull_low", 8'(got.scl_low), 8'(want.scl_low));
        cmp("sda_pull_low", 8'(got.sda_low), 8'(want.sda_low));
        cmp("busy_res", 8'(got.busy), 8'(want.busy));
        cmp("done_res", 8'(got.done), 8'(want.done));
        cmp("acked", 8'(got.acked), 8'(want.acked));
        cmp("read_byte", got.rbyte, want.rbyte);
      end
      results++;
    endtask
  endclass

  // Pause after the last result before touching a register.
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Idle style per side: 0 random gaps, 1 back to back, 2 mostly back to back.
  int in_mode  = 2;
  int out_mode = 2;

  i2c_line_tracker sb = new;

  i2cbm_in_if  in_ch ();
  i2cbm_out_if out_ch ();

  i2c_bit_master_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap(int mode);
    if (mode == 1) return 0;
    if (mode == 2 && $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // ---------------------------------------------------------------------------
  // Register port. Every access first waits for a rising edge so that psel
  // is never lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic read_reg(logic sel, logic [15:0] want);
    @(posedge clk);
    paddr   <= {sel, 2'b00};
    pwrite  <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    // Sample prdata on the completing edge, before the block updates.
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== want) begin
      sb.report($sformatf("register at %0d read %0h expected %0h", {sel, 2'b00},
                          prdata[15:0], want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write one hold register, mirror it in the tracker, then read it back.
  task automatic set_reg(logic sel, logic [15:0] v);
    @(posedge clk);
    paddr   <= {sel, 2'b00};
    pwdata  <= {16'd0, v};
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_SHORT) begin
      sb.short_ticks = v;
    end else begin
      sb.long_ticks = v;
    end
    read_reg(sel, v);
  endtask

  task automatic set_holds(logic [15:0] s, logic [15:0] l);
    set_reg(REG_SHORT, s);
    set_reg(REG_LONG, l);
  endtask

  // ---------------------------------------------------------------------------
  // Tick channel. push_tick is entered and left on a rising edge; valid stays
  // high across back-to-back transfers and drops only when a gap is drawn.
  // ---------------------------------------------------------------------------
  task automatic push_tick(tick_t t);
    int gap;
    gap = draw_gap(in_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd_valid  <= t.cmd_valid;
    in_ch.operation  <= t.op;
    in_ch.write_byte <= t.wbyte;
    in_ch.sda_in     <= t.sda;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    // The transfer happened on this edge: advance the tracker right away so
    // the next tick can be chosen from the sequencer state it leaves.
    sb.note_tick(t);
  endtask

  // SDA pattern: 0 held low, 1 released, anything else random per tick.
  function automatic logic pick_sda(int sda_mode);
    if (sda_mode == 0) return 1'b0;
    if (sda_mode == 1) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // Offer a command on an idle tick and tick until the sequencer is idle again.
  // With nag set, every busy tick, the finishing one included, also carries a
  // command that must be ignored.
  task automatic run_command(op_t op, logic [7:0] b, int sda_mode, bit nag);
    tick_t t;
    t = '0;
    // Flush whatever is still in progress with plain ticks.
    while (sb.busy()) begin
      t.sda = pick_sda(2);
      push_tick(t);
    end
    t.cmd_valid = 1'b1;
    t.op        = op;
    t.wbyte     = b;
    t.sda       = pick_sda(sda_mode);
    push_tick(t);
    while (sb.busy()) begin
      t.cmd_valid = nag;
      t.op        = op_t'($urandom_range(0, 3));
      t.wbyte     = 8'($urandom);
      t.sda       = pick_sda(sda_mode);
      push_tick(t);
    end
  endtask

  task automatic any_command(op_t op);
    run_command(op, 8'($urandom), $urandom_range(0, 3), $urandom_range(0, 3) == 0);
  endtask

  // Mostly complete bus transactions with random content, the rest single
  // commands out of order and stray ticks with no command.
  task automatic random_traffic(int n);
    int    stop_at;
    int    sel;
    bit    rd;
    tick_t t;
    stop_at = sb.ticks + n;
    while (sb.ticks < stop_at) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        rd = 1'($urandom_range(0, 1));
        any_command(OP_START);
        any_command(OP_WRITE);
        repeat ($urandom_range(1, 3)) any_command(rd ? OP_READ : OP_WRITE);
        any_command(OP_STOP);
      end else if (sel < 9) begin
        any_command(op_t'($urandom_range(0, 3)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          t           = '0;
          t.op        = op_t'($urandom_range(0, 3));
          t.wbyte     = 8'($urandom);
          t.sda       = pick_sda(2);
          push_tick(t);
        end
      end
    end
  endtask

  // Drop valid, wait for every owed line state, then let the pipeline drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall ready for a drawn number of cycles per transfer and
  // check each transfer against the oldest owed line state.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    stall = draw_gap(out_mode);
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        sb.check_lines({out_ch.scl_pull_low, out_ch.sda_pull_low, out_ch.busy_res,
                        out_ch.done_res, out_ch.acked, out_ch.read_byte});
        stall = draw_gap(out_mode);
        if (stall != 0) out_ch.ready <= 1'b0;
      end else if (out_ch.ready !== 1'b1) begin
        if (stall > 0) stall--;
        if (stall == 0) out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] s;
    logic [15:0] l;
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd_valid  <= 1'b0;
    in_ch.operation  <= OP_START;
    in_ch.write_byte <= '0;
    in_ch.sda_in     <= 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hold registers come out of reset at their defaults; run one start on them.
    read_reg(REG_SHORT, SHORT_RESET);
    read_reg(REG_LONG, LONG_RESET);
    run_command(OP_START, 8'h00, 2, 1'b0);
    settle();

    // Shortest holds: every command, byte extremes, ack and nack, reads of all
    // ones and all zeros, and commands offered while busy and on the done tick.
    set_holds(16'd1, 16'd1);
    run_command(OP_START, 8'h00, 2, 1'b0);
    run_command(OP_WRITE, 8'hFF, 0, 1'b0);
    run_command(OP_WRITE, 8'h00, 1, 1'b0);
    run_command(OP_WRITE, 8'hA5, 2, 1'b1);
    run_command(OP_READ, 8'h00, 1, 1'b0);
    run_command(OP_READ, 8'hFF, 0, 1'b0);
    run_command(OP_READ, 8'h3C, 2, 1'b1);
    run_command(OP_STOP, 8'h00, 2, 1'b0);
    run_command(OP_STOP, 8'hFF, 2, 1'b1);
    run_command(OP_READ, 8'h5A, 2, 1'b0);
    settle();

    // A zero hold acts as a single tick.
    set_holds(16'd0, 16'd0);
    run_command(OP_START, 8'h00, 2, 1'b1);
    run_command(OP_WRITE, 8'h5A, 2, 1'b0);
    run_command(OP_READ, 8'h00, 2, 1'b0);
    run_command(OP_STOP, 8'h00, 2, 1'b0);
    settle();

    // Random traffic over several hold settings and idle styles.
    for (int p = 0; p < 6; p++) begin
      s = (p == 0) ? 16'd1 : 16'($urandom_range(1, 6));
      l = (p == 0) ? 16'd2 : 16'($urandom_range(1, 5));
      set_holds(s, l);
      in_mode  = p % 3;
      out_mode = (p + 1) % 3;
      random_traffic(100);
      settle();
    end

    // Widest holds: full 16-bit values written and read back.
    set_holds(16'hFFFF, 16'hFFFF);

    // Back to short holds with random idling to close out.
    in_mode  = 0;
    out_mode = 0;
    set_holds(16'd2, 16'd3);
    random_traffic(60);
    settle();

    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Far beyond the slowest correct run with the longest stalls on both sides.
  initial begin : watchdog
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
